// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the encoder RTL.
// Each macro wraps one concurrent property clocked on the rising edge and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds in that cycle.
`define LPBE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("lpbe assertion failed");

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define LPBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("lpbe assertion failed");

`endif

// ===== hdl/lpbe_pkg.sv =====
// Package for the LED pixel brightness encoder: widths, frame constants and tables.
// Used by every module of the encoder; depends on nothing.
`default_nettype none

package lpbe_pkg;

  localparam int unsigned LEVEL_WIDTH  = 32;
  localparam int unsigned CHAN_WIDTH   = 8;
  localparam int unsigned BRIGHT_WIDTH = 5;
  localparam int unsigned RESC_WIDTH   = 24;
  localparam int unsigned NUM_LANES    = 3;

  // Brightness runs from 1 to BRIGHT_MAX; BRIGHT_MAX - 1 thresholds separate the steps.
  localparam int unsigned BRIGHT_MAX   = 31;
  localparam int unsigned BRIGHT_STEPS = BRIGHT_MAX - 1;
  localparam longint unsigned CUBE_255 = 64'd255 * 64'd255 * 64'd255;

  // Pipeline depths: front end (peak, compare, encode) and divider lane.
  localparam int unsigned FRONT_DEPTH = 3;
  localparam int unsigned LANE_DEPTH  = CHAN_WIDTH + 1;
  localparam int unsigned LATENCY     = FRONT_DEPTH + LANE_DEPTH + 1;

  localparam logic [CHAN_WIDTH-1:0] FRAME_MARK = 8'hE0;
  localparam logic [31:0]           DARK_WORD  = 32'h0000_00FF;

  typedef logic [LEVEL_WIDTH-1:0] thresh_arr_t [BRIGHT_STEPS];
  typedef logic [RESC_WIDTH-1:0]  resc_arr_t   [2**BRIGHT_WIDTH];

  // Control and scale that the front end hands to the lanes and the merge stage.
  typedef struct packed {
    logic                    valid;
    logic                    dark;
    logic [BRIGHT_WIDTH-1:0] bright;
    logic [RESC_WIDTH-1:0]   rescaler;
  } bright_beat_t;

  // The brightness exceeds k exactly when the peak is above 255 * ceil(k * 255^3 / 31).
  function automatic thresh_arr_t make_thresh();
    thresh_arr_t     t;
    longint unsigned c;
    for (int k = 1; k <= BRIGHT_STEPS; k++) begin
      c = (longint'(k) * CUBE_255 + BRIGHT_MAX - 1) / BRIGHT_MAX;
      t[k-1] = LEVEL_WIDTH'(64'd255 * c);
    end
    return t;
  endfunction

  // Rescaler for each brightness: 255^3 * brightness / 31, truncated.
  function automatic resc_arr_t make_resc();
    resc_arr_t r;
    for (int b = 0; b < 2**BRIGHT_WIDTH; b++) begin
      r[b] = RESC_WIDTH'(CUBE_255 * longint'(b) / BRIGHT_MAX);
    end
    return r;
  endfunction

  localparam thresh_arr_t THRESH    = make_thresh();
  localparam resc_arr_t   RESC_TABLE = make_resc();

endpackage

`default_nettype wire

// ===== hdl/lpbe_bright.sv =====
// Front end of the encoder: peak of the three channels, brightness and rescaler lookup.
// Three registered stages; uses lpbe_pkg for the threshold and rescaler tables.
`default_nettype none

module lpbe_bright #(
  parameter int unsigned LEVEL_WIDTH = lpbe_pkg::LEVEL_WIDTH
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  input  wire logic [LEVEL_WIDTH-1:0]   level_i [lpbe_pkg::NUM_LANES],
  output lpbe_pkg::bright_beat_t        beat_o,
  output logic      [LEVEL_WIDTH-1:0]   level_o [lpbe_pkg::NUM_LANES]
);

  localparam int unsigned NL = lpbe_pkg::NUM_LANES;
  localparam int unsigned NS = lpbe_pkg::BRIGHT_STEPS;

  logic                   valid1_q, valid2_q, valid3_q;
  logic [LEVEL_WIDTH-1:0] peak_d, peak_q;
  logic [LEVEL_WIDTH-1:0] level1_q [NL];
  logic [LEVEL_WIDTH-1:0] level2_q [NL];
  logic [LEVEL_WIDTH-1:0] level3_q [NL];
  logic [NS-1:0]          therm_d, therm_q;
  logic                   dark_q;
  logic [lpbe_pkg::BRIGHT_WIDTH-1:0] bright_d;
  logic                              dark3_q;
  logic [lpbe_pkg::BRIGHT_WIDTH-1:0] bright3_q;
  logic [lpbe_pkg::RESC_WIDTH-1:0]   resc3_q;

  // Peak of the three channels.
  always_comb begin
    peak_d = level_i[0];
    for (int i = 1; i < NL; i++) begin
      if (level_i[i] > peak_d) peak_d = level_i[i];
    end
  end

  // Compare the peak against every brightness threshold at once.
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      therm_d[k] = peak_q > lpbe_pkg::THRESH[k];
    end
  end

  // The thermometer count plus one is the brightness.
  assign bright_d = lpbe_pkg::BRIGHT_WIDTH'($countones(therm_q)) + 1'b1;

  // Control pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
    end
  end

  // Payload pipeline.
  always_ff @(posedge clk_i) begin
    peak_q    <= peak_d;
    therm_q   <= therm_d;
    dark_q    <= peak_q == '0;
    dark3_q   <= dark_q;
    bright3_q <= bright_d;
    resc3_q   <= lpbe_pkg::RESC_TABLE[bright_d];
    level1_q  <= level_i;
    level2_q  <= level1_q;
    level3_q  <= level2_q;
  end

  assign beat_o  = {valid3_q, dark3_q, bright3_q, resc3_q};
  assign level_o = level3_q;

endmodule

`default_nettype wire

// ===== hdl/lpbe_lane.sv =====
// One channel lane: pipelined restoring divider, one quotient bit per stage, saturating at 255.
// Uses lpbe_pkg for widths and depth.
`default_nettype none

module lpbe_lane #(
  parameter int unsigned LEVEL_WIDTH = lpbe_pkg::LEVEL_WIDTH
) (
  input  wire logic                              clk_i,
  input  wire logic [LEVEL_WIDTH-1:0]            level_i,
  input  wire logic [lpbe_pkg::RESC_WIDTH-1:0]   rescaler_i,
  output logic      [lpbe_pkg::CHAN_WIDTH-1:0]   quotient_o
);

  localparam int unsigned QB = lpbe_pkg::CHAN_WIDTH;

  logic [LEVEL_WIDTH-1:0]          rem_q  [QB+1];
  logic [lpbe_pkg::RESC_WIDTH-1:0] div_q  [QB+1];
  logic [QB-1:0]                   quot_q [QB+1];
  logic                            sat_q  [QB+1];

  // First stage: a level at or above 256 times the rescaler saturates the channel.
  always_ff @(posedge clk_i) begin
    sat_q[0]  <= level_i >= (LEVEL_WIDTH'(rescaler_i) << QB);
    rem_q[0]  <= level_i;
    div_q[0]  <= rescaler_i;
    quot_q[0] <= '0;
  end

  // One trial subtraction per stage, most significant quotient bit first.
  for (genvar s = 1; s <= QB; s++) begin : g_step
    localparam int unsigned BIT = QB - s;
    logic [LEVEL_WIDTH-1:0] trial_d;
    logic                   take_d;
    logic [QB-1:0]          quot_d;

    assign trial_d = LEVEL_WIDTH'(div_q[s-1]) << BIT;
    assign take_d  = rem_q[s-1] >= trial_d;

    always_comb begin
      quot_d      = quot_q[s-1];
      quot_d[BIT] = take_d;
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= take_d ? rem_q[s-1] - trial_d : rem_q[s-1];
      div_q[s]  <= div_q[s-1];
      quot_q[s] <= quot_d;
      sat_q[s]  <= sat_q[s-1];
    end
  end

  assign quotient_o = sat_q[QB] ? '1 : quot_q[QB];

endmodule

`default_nettype wire

// ===== hdl/led_pixel_brightness_encoder_core.sv =====
// Top level of the LED pixel brightness encoder: front end, three channel lanes, merge stage.
// Depends on lpbe_pkg, lpbe_bright, lpbe_lane and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

// Takes one pixel per clock: busy_o is always low, so a beat is accepted at every
// cycle in which start_i is high. The frame word appears on frame_word_o with done_o
// high for one cycle once the beat has passed three front-end stages
// (peak, threshold compares, brightness encode and rescaler lookup), nine divider
// stages per channel lane (saturation check and one quotient bit per stage) and the
// merge register. The receiver cannot stall, so every result must be taken in the
// cycle it is shown; results come out in input order.
module led_pixel_brightness_encoder_core #(
  parameter int unsigned LEVEL_WIDTH = lpbe_pkg::LEVEL_WIDTH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  output logic                        busy_o,
  input  wire logic [LEVEL_WIDTH-1:0] red_level_i,
  input  wire logic [LEVEL_WIDTH-1:0] green_level_i,
  input  wire logic [LEVEL_WIDTH-1:0] blue_level_i,
  output logic                        done_o,
  output logic [31:0]                 frame_word_o
);

  localparam int unsigned NL = lpbe_pkg::NUM_LANES;
  localparam int unsigned LD = lpbe_pkg::LANE_DEPTH;
  localparam int unsigned CW = lpbe_pkg::CHAN_WIDTH;

  logic                   accept;
  logic [LEVEL_WIDTH-1:0] level_in [NL];
  logic [LEVEL_WIDTH-1:0] level_fe [NL];
  logic [CW-1:0]          quot     [NL];
  lpbe_pkg::bright_beat_t fe_beat;

  logic                              valid_q  [LD];
  logic                              dark_q   [LD];
  logic [lpbe_pkg::BRIGHT_WIDTH-1:0] bright_q [LD];

  logic        done_q;
  logic [31:0] word_d, word_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign level_in[0] = red_level_i;
  assign level_in[1] = green_level_i;
  assign level_in[2] = blue_level_i;

  // Brightness and rescaler for the whole pixel.
  lpbe_bright #(
    .LEVEL_WIDTH(LEVEL_WIDTH)
  ) u_bright (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(accept),
    .level_i(level_in),
    .beat_o (fe_beat),
    .level_o(level_fe)
  );

  // One divider lane per colour channel.
  for (genvar l = 0; l < NL; l++) begin : g_lane
    lpbe_lane #(
      .LEVEL_WIDTH(LEVEL_WIDTH)
    ) u_lane (
      .clk_i     (clk_i),
      .level_i   (level_fe[l]),
      .rescaler_i(fe_beat.rescaler),
      .quotient_o(quot[l])
    );
  end

  // Carry the control of each beat alongside the lanes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LD; i++) valid_q[i] <= 1'b0;
    end else begin
      valid_q[0] <= fe_beat.valid;
      for (int i = 1; i < LD; i++) valid_q[i] <= valid_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    dark_q[0]   <= fe_beat.dark;
    bright_q[0] <= fe_beat.bright;
    for (int i = 1; i < LD; i++) begin
      dark_q[i]   <= dark_q[i-1];
      bright_q[i] <= bright_q[i-1];
    end
  end

  // Merge the three channel quotients and the brightness into the frame word, or give the dark word for a dark pixel.
  always_comb begin
    if (dark_q[LD-1]) begin
      word_d = lpbe_pkg::DARK_WORD;
    end else begin
      word_d = {quot[0], quot[1], quot[2],
                lpbe_pkg::FRAME_MARK | CW'(bright_q[LD-1])};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_q[LD-1];
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign done_o       = done_q;
  assign frame_word_o = word_q;

  // Every accepted pixel yields its word once it has passed through the whole pipeline.
  `LPBE_ASSERT_IMPL(a_latency, clk_i, rst_ni, accept, ##(lpbe_pkg::LATENCY) done_o)
  // A lit pixel always carries the frame mark and a non-zero brightness.
  `LPBE_ASSERT_IMPL(a_mark, clk_i, rst_ni, done_o && frame_word_o != lpbe_pkg::DARK_WORD,
                    frame_word_o[7:5] == 3'b111 && frame_word_o[4:0] != 5'd0)
  // A dark pixel comes out as the dark word.
  `LPBE_ASSERT_NEXT(a_dark, clk_i, rst_ni, valid_q[LD-1] && dark_q[LD-1],
                    frame_word_o == lpbe_pkg::DARK_WORD)
  // The merge stage follows the last lane stage in the next cycle.
  `LPBE_ASSERT_NEXT(a_merge, clk_i, rst_ni, valid_q[LD-1], done_o)

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the LED pixel brightness encoder core.
// Depends on lpbe_pkg and led_pixel_brightness_encoder_core; needs nothing else.
module tb;

  localparam int unsigned    RANDOM_PIXELS = 2000;
  localparam int unsigned    CALM_TAIL     = 200;
  localparam int unsigned    STALL_LIMIT   = 2000;
  localparam logic [31:0]    FULL_LEVEL    = 32'd4228250625;
  localparam logic [31:0]    TOP_LEVEL     = 32'hFFFF_FFFF;
  localparam longint unsigned CUBE         = 64'd16581375;
  localparam longint unsigned PEAK_BRIGHT  = 64'd31;
  localparam logic [7:0]     SYNC_BITS     = 8'hE0;
  localparam logic [31:0]    UNLIT_WORD    = 32'h0000_00FF;

  typedef struct {
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    bit          typed;
    logic [31:0] word;
  } pixel_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [31:0] red_level_i = '0;
  logic [31:0] green_level_i = '0;
  logic [31:0] blue_level_i = '0;
  logic        busy_o;
  logic        done_o;
  logic [31:0] frame_word_o;

  // Row flag and word for beats whose expected word is typed into the table.
  bit          typed_row = 1'b0;
  logic [31:0] typed_word = '0;

  logic [31:0] frame_word_q [$];
  pixel_row_t  pixel_table [$];
  int unsigned word_mismatches = 0;
  int unsigned stall_cycles = 0;

  led_pixel_brightness_encoder_core #(
    .LEVEL_WIDTH(lpbe_pkg::LEVEL_WIDTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .red_level_i  (red_level_i),
    .green_level_i(green_level_i),
    .blue_level_i (blue_level_i),
    .done_o       (done_o),
    .frame_word_o (frame_word_o)
  );

  always #4 clk_i = ~clk_i;

  // Divides one channel by the rescaler and clips the quotient to eight bits.
  function automatic logic [7:0] clip_channel(input logic [31:0] level,
                                              input longint unsigned rescaler);
    longint unsigned quot;
    quot = longint'(level) / rescaler;
    return (quot > 64'd255) ? 8'hFF : quot[7:0];
  endfunction

  // Predicts the frame word: the peak channel picks the brightness, which sets the rescaler.
  function automatic logic [31:0] encode_frame_word(input logic [31:0] red,
                                                    input logic [31:0] green,
                                                    input logic [31:0] blue);
    longint unsigned peak;
    longint unsigned bright;
    longint unsigned rescaler;
    peak = red;
    if (green > peak) peak = green;
    if (blue > peak) peak = blue;
    if (peak == 0) return UNLIT_WORD;
    bright = ((peak - 1) / 255 * PEAK_BRIGHT / CUBE) + 1;
    if (bright > PEAK_BRIGHT) bright = PEAK_BRIGHT;
    rescaler = CUBE * bright / PEAK_BRIGHT;
    return {clip_channel(red, rescaler), clip_channel(green, rescaler),
            clip_channel(blue, rescaler), SYNC_BITS | {3'b000, bright[4:0]}};
  endfunction

  task automatic note_mismatch(input logic [31:0] want, input bit waiting);
    if (word_mismatches < 10) begin
      if (waiting) begin
        $display("frame word mismatch: expected %h, got %h", want, frame_word_o);
      end else begin
        $display("frame word %h arrived with nothing expected", frame_word_o);
      end
    end
    word_mismatches++;
  endtask

  // Checks each result beat against the oldest expectation, then books accepted pixels.
  always @(posedge clk_i) begin : monitor
    logic [31:0] want;
    bit          moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (done_o) begin
        moved = 1'b1;
        if (frame_word_q.size() == 0) begin
          note_mismatch('0, 1'b0);
        end else begin
          want = frame_word_q.pop_front();
          if (frame_word_o !== want) note_mismatch(want, 1'b1);
        end
      end
      if (start_i && !busy_o) begin
        moved = 1'b1;
        frame_word_q.push_back(typed_row ? typed_word :
                               encode_frame_word(red_level_i, green_level_i, blue_level_i));
      end
    end
    // Watchdog on cycles in which no beat moves on either side.
    if (moved) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Presents one pixel and holds it until the block takes the beat.
  task automatic send_pixel(input logic [31:0] red, input logic [31:0] green,
                            input logic [31:0] blue, input bit typed,
                            input logic [31:0] word);
    start_i       <= 1'b1;
    red_level_i   <= red;
    green_level_i <= green;
    blue_level_i  <= blue;
    typed_row     <= typed;
    typed_word    <= word;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic hold_off(input int unsigned cycles);
    start_i   <= 1'b0;
    typed_row <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_results();
    start_i   <= 1'b0;
    typed_row <= 1'b0;
    @(posedge clk_i);
    while (frame_word_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [31:0]     lv [3];
    logic [31:0]     peak_level;
    longint unsigned step_edge;
    int unsigned     kind;
    int unsigned     lead;
    pixel_row_t      row;

    // Directed table: extremes, dark pixel, single channels, brightness boundaries.
    pixel_table.push_back('{32'd0, 32'd0, 32'd0, 1'b1, UNLIT_WORD});
    pixel_table.push_back('{FULL_LEVEL, FULL_LEVEL, FULL_LEVEL, 1'b1, 32'hFFFF_FFFF});
    pixel_table.push_back('{TOP_LEVEL, TOP_LEVEL, TOP_LEVEL, 1'b1, 32'hFFFF_FFFF});
    pixel_table.push_back('{32'd1, 32'd0, 32'd0, 1'b1, 32'h0000_00E1});
    pixel_table.push_back('{32'd0, 32'd1, 32'd0, 1'b1, 32'h0000_00E1});
    pixel_table.push_back('{32'd0, 32'd0, 32'd1, 1'b1, 32'h0000_00E1});
    pixel_table.push_back('{FULL_LEVEL, 32'd0, 32'd0, 1'b1, 32'hFF00_00FF});
    pixel_table.push_back('{32'd0, FULL_LEVEL, 32'd0, 1'b1, 32'h00FF_00FF});
    pixel_table.push_back('{32'd0, 32'd0, FULL_LEVEL, 1'b1, 32'h0000_FFFF});
    pixel_table.push_back('{TOP_LEVEL, 32'd0, 32'd0, 1'b1, 32'hFF00_00FF});
    pixel_table.push_back('{FULL_LEVEL + 32'd1, 32'd0, 32'd0, 1'b0, '0});
    pixel_table.push_back('{32'd0, TOP_LEVEL, 32'd1, 1'b0, '0});
    pixel_table.push_back('{FULL_LEVEL, FULL_LEVEL - 32'd1, 32'd1, 1'b0, '0});
    pixel_table.push_back('{32'h8000_0000, 32'h4000_0000, 32'h2000_0000, 1'b0, '0});
    pixel_table.push_back('{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0});
    pixel_table.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0});
    pixel_table.push_back('{32'd255, 32'd0, 32'd0, 1'b0, '0});
    pixel_table.push_back('{32'd256, 32'd1, 32'd0, 1'b0, '0});
    pixel_table.push_back('{32'd136395420, 32'd534883, 32'd0, 1'b0, '0});
    pixel_table.push_back('{32'd136395421, 32'd0, 32'd534882, 1'b0, '0});
    pixel_table.push_back('{32'd0, 32'd4091855460, 32'd1000, 1'b0, '0});
    pixel_table.push_back('{32'd4091855461, 32'd4091855460, 32'd0, 1'b0, '0});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (pixel_table[i]) begin
      row = pixel_table[i];
      send_pixel(row.red, row.green, row.blue, row.typed, row.word);
    end
    // Let the pipeline run empty once before the random part.
    drain_results();

    for (int unsigned n = 0; n < RANDOM_PIXELS; n++) begin
      kind = $urandom_range(9, 0);
      lead = $urandom_range(2, 0);
      case (kind)
        0: begin
          foreach (lv[c]) lv[c] = $urandom();
        end
        1, 2, 3, 4: begin
          foreach (lv[c]) lv[c] = $urandom_range(FULL_LEVEL, 0);
        end
        5: begin
          // Peak sits on a brightness step boundary, give or take one.
          step_edge = 64'd255 * ((longint'($urandom_range(30, 1)) * CUBE + 30) / 31);
          peak_level = step_edge[31:0] + $urandom_range(2, 0) - 32'd1;
          foreach (lv[c]) lv[c] = $urandom_range(peak_level, 0);
          lv[lead] = peak_level;
        end
        6: begin
          foreach (lv[c]) lv[c] = ($urandom_range(1, 0) != 0) ? $urandom_range(1000, 0) : '0;
        end
        7: begin
          peak_level = $urandom();
          foreach (lv[c]) lv[c] = ($urandom_range(3, 0) != 0) ? $urandom_range(peak_level, 0) : '0;
          lv[lead] = peak_level;
        end
        default: begin
          // Around full scale, on either side of it.
          foreach (lv[c]) lv[c] = $urandom_range(FULL_LEVEL, 0);
          lv[lead] = FULL_LEVEL - 32'd1000 + $urandom_range(2000, 0);
        end
      endcase
      send_pixel(lv[0], lv[1], lv[2], 1'b0, '0);
      if (n == RANDOM_PIXELS / 2) begin
        drain_results();
      end else if (n < RANDOM_PIXELS - CALM_TAIL && $urandom_range(5, 0) == 0) begin
        hold_off($urandom_range(4, 1));
      end
    end

    drain_results();
    repeat (lpbe_pkg::LATENCY + 4) @(posedge clk_i);
    if (word_mismatches == 0 && frame_word_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/lpbe_pkg.sv
hdl/lpbe_bright.sv
hdl/lpbe_lane.sv
hdl/led_pixel_brightness_encoder_core.sv
tb/sv/tb.sv
